// ===== rtl/dsa_pkg.sv =====
package dsa_pkg;

    // request kinds
    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_READ    = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADMARK = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ALIGN_W = 4;
    localparam int unsigned TOP_W   = DATA_W + 1;
    localparam int unsigned CALC_W  = DATA_W + 2;

    // widest address an allocation may produce
    localparam int unsigned ADDR_BITS = 32;
    localparam logic [CALC_W-1:0] FIT_LIMIT = (ADDR_BITS >= DATA_W)
        ? {2'b00, {DATA_W{1'b1}}}
        : ((CALC_W'(1) << ADDR_BITS) - CALC_W'(1));

    localparam logic [DATA_W-1:0] BASE_RESET = 32'd0;
    localparam logic [DATA_W-1:0] SIZE_RESET = 32'd65536;

endpackage

// ===== rtl/double_ended_stack_allocator.sv =====
// double-ended stack allocator
// a region [base, base+size) is carved from both ends: the bottom end grows
// up, the top end grows down, and they must never cross
// input channel: i_valid/o_ready carry one request word (type, end select,
// size, alignment, marker); output channel: o_valid/i_ready carry one result
// word (address, status) per request, in request order
// config port: i_cfg_we writes region_base (index 0) or region_size
// (index 1) at once; either write puts both ends back at the region edges
// an accepted word goes to the input register, then to the result register
// throughput: one word per cycle while i_ready stays high; the end pointers
// are read and updated by the add, mask and compare logic of the compute
// stage, so the next word sees the new pointers without a bubble
// stalls: when the receiver holds i_ready low the result register keeps its
// word, the input register still takes one more word, then o_ready drops
// reset (i_rst_n low, synchronous) empties both registers, loads base 0 and
// size 65536, and places the ends at the region edges
module double_ended_stack_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic                        i_from_top,
    input  logic [dsa_pkg::DATA_W-1:0]  i_alloc_size,
    input  logic [dsa_pkg::ALIGN_W-1:0] i_align_log2,
    input  logic [dsa_pkg::DATA_W-1:0]  i_marker_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dsa_pkg::DATA_W-1:0]  o_address,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [dsa_pkg::DATA_W-1:0]  i_cfg_wdata
);
    import dsa_pkg::*;

    // configuration and end pointers
    logic [DATA_W-1:0]  r_base;
    logic [DATA_W-1:0]  r_size;
    logic [TOP_W-1:0]   r_top;
    logic [DATA_W-1:0]  r_bottom;

    // input register
    logic               r_in_valid;
    logic [1:0]         r_req;
    logic               r_from_top;
    logic [DATA_W-1:0]  r_alloc_size;
    logic [ALIGN_W-1:0] r_align;
    logic [DATA_W-1:0]  r_marker;

    // result register
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_address;
    logic [1:0]         r_status;

    logic               move;
    logic [CALC_W-1:0]  amask;
    logic [CALC_W-1:0]  top_ext;
    logic [CALC_W-1:0]  bot_ext;
    logic [CALC_W-1:0]  size_ext;
    logic [CALC_W-1:0]  mark_ext;
    logic [CALC_W-1:0]  limit_ext;
    logic [CALC_W-1:0]  top_diff;
    logic [CALC_W-1:0]  top_addr;
    logic [CALC_W-1:0]  bot_addr;
    logic [CALC_W-1:0]  bot_next;
    logic               top_ok;
    logic               bot_ok;
    logic               mark_ok;
    logic [TOP_W-1:0]   n_top;
    logic [DATA_W-1:0]  n_bottom;
    logic [DATA_W-1:0]  n_address;
    logic [1:0]         n_status;

    // compute stage fires when the result register is free or draining
    assign move    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || move;

    assign amask     = (CALC_W'(1) << r_align) - CALC_W'(1);
    assign top_ext   = {1'b0, r_top};
    assign bot_ext   = {2'b00, r_bottom};
    assign size_ext  = {2'b00, r_alloc_size};
    assign mark_ext  = {2'b00, r_marker};
    assign limit_ext = {2'b00, r_base} + {2'b00, r_size};

    // top end: subtract, then round down to the alignment
    assign top_diff = top_ext - size_ext;
    assign top_addr = top_diff & ~amask;
    assign top_ok   = (size_ext <= top_ext) && (top_addr >= bot_ext)
                      && (top_addr <= FIT_LIMIT);

    // bottom end: round up to the alignment, then add
    assign bot_addr = (bot_ext + amask) & ~amask;
    assign bot_next = bot_addr + size_ext;
    assign bot_ok   = (bot_next <= top_ext) && (bot_next <= FIT_LIMIT);

    // marker must lie in the region and not cross the other end
    assign mark_ok = (r_marker >= r_base) && (mark_ext <= limit_ext)
                     && (r_from_top ? (r_marker >= r_bottom) : (mark_ext <= top_ext));

    always_comb begin
        n_top     = r_top;
        n_bottom  = r_bottom;
        n_address = '0;
        n_status  = ST_OK;
        case (t_req'(r_req))
            REQ_ALLOC: begin
                n_status = ST_NOSPACE;
                if (r_alloc_size != '0) begin
                    if (r_from_top) begin
                        if (top_ok) begin
                            n_top     = top_addr[TOP_W-1:0];
                            n_address = top_addr[DATA_W-1:0];
                            n_status  = ST_OK;
                        end
                    end else begin
                        if (bot_ok) begin
                            n_bottom  = bot_next[DATA_W-1:0];
                            n_address = bot_addr[DATA_W-1:0];
                            n_status  = ST_OK;
                        end
                    end
                end
            end
            REQ_RELEASE: begin
                if (mark_ok) begin
                    if (r_from_top) begin
                        n_top = {1'b0, r_marker};
                    end else begin
                        n_bottom = r_marker;
                    end
                    n_address = r_marker;
                end else begin
                    n_status = ST_BADMARK;
                end
            end
            REQ_READ: begin
                n_address = r_from_top ? r_top[DATA_W-1:0] : r_bottom;
            end
            default: begin
                // unused request kind: empty ok result
                n_address = '0;
            end
        endcase
    end

    // control state and end pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
            r_size      <= SIZE_RESET;
            r_top       <= {1'b0, BASE_RESET} + {1'b0, SIZE_RESET};
            r_bottom    <= BASE_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                // either write resets both ends to the new region edges
                if (i_cfg_index == CFG_BASE) begin
                    r_base   <= i_cfg_wdata;
                    r_top    <= {1'b0, i_cfg_wdata} + {1'b0, r_size};
                    r_bottom <= i_cfg_wdata;
                end else begin
                    r_size   <= i_cfg_wdata;
                    r_top    <= {1'b0, r_base} + {1'b0, i_cfg_wdata};
                    r_bottom <= r_base;
                end
            end else if (move) begin
                r_top    <= n_top;
                r_bottom <= n_bottom;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req        <= i_req_type;
            r_from_top   <= i_from_top;
            r_alloc_size <= i_alloc_size;
            r_align      <= i_align_log2;
            r_marker     <= i_marker_value;
        end
        if (move) begin
            r_address <= n_address;
            r_status  <= n_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_address = r_address;
    assign o_status  = r_status;

endmodule

// ===== rtl/dsa_checker.sv =====
module dsa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [dsa_pkg::DATA_W-1:0] o_address,
    input logic [1:0]                 o_status
);
    import dsa_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_address) && $stable(o_status))
        else $error("result word changed while stalled");

    // failed requests return address zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOSPACE || o_status == ST_BADMARK)
        |-> o_address == '0)
        else $error("failed request with nonzero address");

    // no undefined status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NOSPACE
                     || o_status == ST_BADMARK))
        else $error("undefined status code");

    // a fresh result needs a word accepted through the input register
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result without accepted request");

endmodule

bind double_ended_stack_allocator dsa_checker u_dsa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_address (o_address),
    .o_status  (o_status)
);
